>>> hw/rtl/ng_pkg.sv
// Shared types, codes and constants of the noise gate envelope block.
// No dependencies; every other file of the block depends on this package.
package ng_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 16;
    localparam int TICK_BITS_DEFAULT   = 16;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int THRESH_BITS    = 15;
    localparam int LENGTH_BITS    = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int COMMAND_BITS   = 8;
    localparam int MODE_BITS      = 3;

    localparam logic [THRESH_BITS-1:0] OPEN_THRESHOLD_RESET  = 15'd16384;
    localparam logic [THRESH_BITS-1:0] CLOSE_THRESHOLD_RESET = 15'd16384;
    localparam logic [LENGTH_BITS-1:0] LENGTH_RESET          = 16'd0;
    localparam logic [GAIN_BITS-1:0]   OUTPUT_GAIN_RESET     = 16'd4096;

    localparam logic OPCODE_SAMPLE  = 1'b0;
    localparam logic OPCODE_COMMAND = 1'b1;
    localparam logic [COMMAND_BITS-1:0] CMD_BYPASS = 8'h00;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_OPEN_THRESHOLD  = 3'd0,
        REG_CLOSE_THRESHOLD = 3'd1,
        REG_ATTACK_LENGTH   = 3'd2,
        REG_HOLD_LENGTH     = 3'd3,
        REG_RELEASE_LENGTH  = 3'd4,
        REG_OUTPUT_GAIN     = 3'd5
    } ng_cfg_reg_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_OFF     = 3'd0,
        MODE_ATTACK  = 3'd1,
        MODE_ON      = 3'd2,
        MODE_HOLD    = 3'd3,
        MODE_RELEASE = 3'd4,
        MODE_BYPASS  = 3'd5
    } ng_mode_t;

    // How the envelope gain applies to one sample.
    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_RATIO = 2'd2
    } ng_kind_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] open_threshold;
        logic [THRESH_BITS-1:0] close_threshold;
        logic [LENGTH_BITS-1:0] attack_length;
        logic [LENGTH_BITS-1:0] hold_length;
        logic [LENGTH_BITS-1:0] release_length;
        logic [GAIN_BITS-1:0]   output_gain;
    } ng_cfg_t;

    // Commands from the sequencer to the datapath and envelope tracker.
    typedef struct packed {
        logic take_audio;
        logic take_command;
        logic mul;
        logic div_step;
        logic gain;
        logic emit;
    } ng_cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic need_div;
        logic out_free;
    } ng_status_t;

endpackage

>>> hw/rtl/ng_item_if.sv
// Input channel of the noise gate: valid/ready handshake with one item per beat.
// Depends on ng_pkg for widths.
interface ng_item_if #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT
);
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [SAMPLE_BITS-1:0]     sample_in;
    logic [ng_pkg::COMMAND_BITS-1:0]   command_code;

    modport source (output valid, opcode, sample_in, command_code, input ready);
    modport sink   (input valid, opcode, sample_in, command_code, output ready);
endinterface

>>> hw/rtl/ng_result_if.sv
// Output channel of the noise gate: valid/ready handshake with one result per beat.
// Depends on ng_pkg for widths.
interface ng_result_if #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [ng_pkg::MODE_BITS-1:0]  gate_mode_out;

    modport source (output valid, sample_out, gate_mode_out, input ready);
    modport sink   (input valid, sample_out, gate_mode_out, output ready);
endinterface

>>> hw/rtl/ng_cfg.sv
// Configuration register file of the noise gate.
// Depends on ng_pkg for register indexes, widths and reset values.
module ng_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ng_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ng_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output ng_pkg::ng_cfg_t                   cfg
);
    import ng_pkg::*;

    logic [THRESH_BITS-1:0] open_threshold_reg;
    logic [THRESH_BITS-1:0] close_threshold_reg;
    logic [LENGTH_BITS-1:0] attack_length_reg;
    logic [LENGTH_BITS-1:0] hold_length_reg;
    logic [LENGTH_BITS-1:0] release_length_reg;
    logic [GAIN_BITS-1:0]   output_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_threshold_reg  <= OPEN_THRESHOLD_RESET;
            close_threshold_reg <= CLOSE_THRESHOLD_RESET;
            attack_length_reg   <= LENGTH_RESET;
            hold_length_reg     <= LENGTH_RESET;
            release_length_reg  <= LENGTH_RESET;
            output_gain_reg     <= OUTPUT_GAIN_RESET;
        end
        else if (cfg_write)
        begin
            // Indexes beyond the register list are dropped.
            case (cfg_index)
                REG_OPEN_THRESHOLD:  open_threshold_reg  <= cfg_data[THRESH_BITS-1:0];
                REG_CLOSE_THRESHOLD: close_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                REG_ATTACK_LENGTH:   attack_length_reg   <= cfg_data[LENGTH_BITS-1:0];
                REG_HOLD_LENGTH:     hold_length_reg     <= cfg_data[LENGTH_BITS-1:0];
                REG_RELEASE_LENGTH:  release_length_reg  <= cfg_data[LENGTH_BITS-1:0];
                REG_OUTPUT_GAIN:     output_gain_reg     <= cfg_data[GAIN_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        cfg.open_threshold  = open_threshold_reg;
        cfg.close_threshold = close_threshold_reg;
        cfg.attack_length   = attack_length_reg;
        cfg.hold_length     = hold_length_reg;
        cfg.release_length  = release_length_reg;
        cfg.output_gain     = output_gain_reg;
    end

endmodule

>>> hw/rtl/ng_env.sv
// Envelope tracker: gate mode, sample counter and the gain ratio of each sample.
// Depends on ng_pkg for mode codes, gain kinds and the configuration struct.
module ng_env #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT,
    parameter int TICK_BITS   = ng_pkg::TICK_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take_audio,
    input  logic                            take_command,
    input  logic [SAMPLE_BITS-1:0]          sample_in,
    input  logic [ng_pkg::COMMAND_BITS-1:0] command_code,
    input  ng_pkg::ng_cfg_t                 cfg,
    output logic [SAMPLE_BITS-1:0]          mag,
    output logic                            neg,
    output ng_pkg::ng_kind_t                kind,
    output logic [ng_pkg::LENGTH_BITS-1:0]  num,
    output logic [ng_pkg::LENGTH_BITS-1:0]  den,
    output ng_pkg::ng_mode_t                mode_after
);
    import ng_pkg::*;

    localparam int CW = TICK_BITS + 1;
    localparam int LW = (CW > LENGTH_BITS) ? CW : LENGTH_BITS;
    localparam int MW = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

    ng_mode_t       mode_reg, mode_next;
    logic [CW-1:0]  count_reg, count_next, count_base;
    logic           trans;
    logic [LW-1:0]  c_x, alen_x, hlen_x, rlen_x, diff_x;
    logic [MW-1:0]  mag_x, open_x, close_x;

    // The most negative sample negates onto itself, which is its exact magnitude.
    assign neg = sample_in[SAMPLE_BITS-1];
    assign mag = neg ? (~sample_in + 1'b1) : sample_in;

    assign mag_x   = MW'(mag);
    assign open_x  = MW'(cfg.open_threshold);
    assign close_x = MW'(cfg.close_threshold);
    assign c_x     = LW'(count_reg);
    assign alen_x  = LW'(cfg.attack_length);
    assign hlen_x  = LW'(cfg.hold_length);
    assign rlen_x  = LW'(cfg.release_length);
    assign diff_x  = rlen_x - c_x;

    always_comb
    begin
        mode_after = mode_reg;
        trans      = 1'b0;
        kind       = KIND_ONE;
        num        = '0;
        den        = '0;
        case (mode_reg)
            MODE_OFF:
            begin
                kind = KIND_ZERO;
                if (mag_x > open_x)
                begin
                    mode_after = MODE_ATTACK;
                    trans      = 1'b1;
                end
            end
            MODE_ATTACK:
            begin
                // A zero length or a counter at or past the length gives full gain.
                if (alen_x != '0 && c_x < alen_x)
                begin
                    kind = KIND_RATIO;
                    num  = c_x[LENGTH_BITS-1:0];
                    den  = cfg.attack_length;
                end
                if (c_x >= alen_x)
                begin
                    mode_after = MODE_ON;
                    trans      = 1'b1;
                end
            end
            MODE_ON:
            begin
                if (mag_x < close_x)
                begin
                    mode_after = MODE_HOLD;
                    trans      = 1'b1;
                end
            end
            MODE_HOLD:
            begin
                if (mag_x > open_x)
                begin
                    mode_after = MODE_ON;
                    trans      = 1'b1;
                end
                else if (c_x >= hlen_x)
                begin
                    mode_after = MODE_RELEASE;
                    trans      = 1'b1;
                end
            end
            MODE_RELEASE:
            begin
                if (rlen_x == '0 || c_x >= rlen_x)
                begin
                    kind = KIND_ZERO;
                end
                else
                begin
                    kind = KIND_RATIO;
                    num  = diff_x[LENGTH_BITS-1:0];
                    den  = cfg.release_length;
                end
                if (c_x >= rlen_x)
                begin
                    mode_after = MODE_OFF;
                    trans      = 1'b1;
                end
            end
            default:
            begin
                mode_after = MODE_BYPASS;
            end
        endcase
    end

    // The counter restarts after a transition and sticks at its top value.
    assign count_base = trans ? '0 : count_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (take_audio)
        begin
            mode_next  = mode_after;
            count_next = (count_base == '1) ? count_base : count_base + 1'b1;
        end
        else if (take_command && command_code == CMD_BYPASS)
        begin
            mode_next = MODE_BYPASS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/ng_dp.sv
// Arithmetic datapath: ramp multiply, serial divide, output gain, saturation
// and the output register. Depends on ng_pkg for widths, kinds and structs.
module ng_dp #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ng_pkg::ng_cmd_t                cmd,
    output ng_pkg::ng_status_t             status,
    input  logic [SAMPLE_BITS-1:0]         mag,
    input  logic                           neg,
    input  ng_pkg::ng_kind_t               kind,
    input  logic [ng_pkg::LENGTH_BITS-1:0] num,
    input  logic [ng_pkg::LENGTH_BITS-1:0] den,
    input  ng_pkg::ng_mode_t               mode_after,
    input  logic [ng_pkg::GAIN_BITS-1:0]   gain,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [SAMPLE_BITS-1:0]         sample_out,
    output logic [ng_pkg::MODE_BITS-1:0]   gate_mode_out
);
    import ng_pkg::*;

    localparam int PW = SAMPLE_BITS + LENGTH_BITS;
    localparam int GW = SAMPLE_BITS + GAIN_BITS;
    localparam int YW = GW - GAIN_FRAC_BITS;
    localparam logic [YW-1:0] NEG_LIMIT = YW'(1) << (SAMPLE_BITS - 1);
    localparam logic [YW-1:0] POS_LIMIT = NEG_LIMIT - 1'b1;

    logic [SAMPLE_BITS-1:0] mag_reg;
    logic                   neg_reg;
    ng_kind_t               kind_reg;
    logic [LENGTH_BITS-1:0] num_reg, den_reg;
    ng_mode_t               mode_reg;
    logic [LENGTH_BITS-1:0] rem_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;
    logic [GW-1:0]          gprod_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    ng_mode_t               mode_out_reg;

    logic [PW-1:0]          prod;
    logic [LENGTH_BITS:0]   r2, r_sub;
    logic                   ge;
    logic [GW-1:0]          gprod;
    logic [YW-1:0]          y, y_sat;
    logic [SAMPLE_BITS-1:0] result;

    assign prod = PW'(mag_reg) * PW'(num_reg);

    // One quotient bit per step; the quotient is known to fit the sample width,
    // so the upper product bits start out as a remainder below the divisor.
    assign r2    = {rem_reg, quo_reg[SAMPLE_BITS-1]};
    assign ge    = r2 >= {1'b0, den_reg};
    assign r_sub = r2 - {1'b0, den_reg};

    assign gprod = GW'(quo_reg) * GW'(gain);

    assign y = gprod_reg[GW-1:GAIN_FRAC_BITS];

    always_comb
    begin
        if (neg_reg)
        begin
            y_sat  = (y > NEG_LIMIT) ? NEG_LIMIT : y;
            result = ~y_sat[SAMPLE_BITS-1:0] + 1'b1;
        end
        else
        begin
            y_sat  = (y > POS_LIMIT) ? POS_LIMIT : y;
            result = y_sat[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_audio)
        begin
            mag_reg  <= mag;
            neg_reg  <= neg;
            kind_reg <= kind;
            num_reg  <= num;
            den_reg  <= den;
            mode_reg <= mode_after;
        end
        if (cmd.mul)
        begin
            case (kind_reg)
                KIND_RATIO:
                begin
                    rem_reg <= prod[PW-1:SAMPLE_BITS];
                    quo_reg <= prod[SAMPLE_BITS-1:0];
                end
                KIND_ONE: quo_reg <= mag_reg;
                default:  quo_reg <= '0;
            endcase
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? r_sub[LENGTH_BITS-1:0] : r2[LENGTH_BITS-1:0];
            quo_reg <= {quo_reg[SAMPLE_BITS-2:0], ge};
        end
        if (cmd.gain)
        begin
            gprod_reg <= gprod;
        end
        if (cmd.emit)
        begin
            sample_out_reg <= result;
            mode_out_reg   <= mode_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.need_div = (kind_reg == KIND_RATIO);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign gate_mode_out = mode_out_reg;

endmodule

>>> hw/rtl/ng_ctrl.sv
// Sequencer of the noise gate: input handshake and the step order of the datapath.
// Depends on ng_pkg for the opcode and the command and status structs.
module ng_ctrl #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_opcode,
    output logic               item_ready,
    input  ng_pkg::ng_status_t status,
    output ng_pkg::ng_cmd_t    cmd
);
    import ng_pkg::*;

    localparam int DCW = $clog2(SAMPLE_BITS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_GAIN = 5'b01000,
        S_OUT  = 5'b10000
    } ng_state_t;

    ng_state_t      state_reg, state_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           accept;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        cmd.take_audio   = accept && (item_opcode == OPCODE_SAMPLE);
        cmd.take_command = accept && (item_opcode == OPCODE_COMMAND);
        cmd.mul          = (state_reg == S_MUL);
        cmd.div_step     = (state_reg == S_DIV);
        cmd.gain         = (state_reg == S_GAIN);
        cmd.emit         = (state_reg == S_OUT) && status.out_free;
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.take_audio)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (status.need_div)
                begin
                    state_next   = S_DIV;
                    div_cnt_next = DCW'(SAMPLE_BITS - 1);
                end
                else
                begin
                    state_next = S_GAIN;
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = S_GAIN;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            S_GAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

>>> hw/rtl/noise_gate_envelope_top.sv
// Noise gate with attack, hold and release envelope on signed audio samples.
// Top level; depends on ng_pkg, ng_item_if, ng_result_if, ng_cfg, ng_env, ng_ctrl, ng_dp.
//
// The gate works on one item at a time. A command beat is taken while the
// sequencer is idle and gives no result; code zero puts the gate into
// bypass, which only reset leaves. An audio beat gives exactly one result
// beat carrying the gated, amplified and saturated sample together with the
// gate mode after that sample. An accepted audio sample is registered; during
// an attack or release ramp its magnitude is multiplied by the ramp numerator
// and divided by the ramp length in a restoring divider that produces one
// quotient bit per cycle. The magnitude is then multiplied by the output gain
// and written to the result register once that register is free, after which
// the sequencer returns to idle and accepts the next item. A finished result
// waits in the output register, and the next item is accepted while it waits;
// only a second result that cannot be stored holds the sequencer. Configuration
// registers are written through cfg_write, cfg_index and cfg_data and must only
// be changed while no audio beat is in flight.
module noise_gate_envelope_top #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT,
    parameter int TICK_BITS   = ng_pkg::TICK_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ng_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ng_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    ng_item_if.sink                           item,
    ng_result_if.source                       result
);
    import ng_pkg::*;

    ng_cfg_t                cfg;
    ng_cmd_t                cmd;
    ng_status_t             status;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   neg;
    ng_kind_t               kind;
    logic [LENGTH_BITS-1:0] num;
    logic [LENGTH_BITS-1:0] den;
    ng_mode_t               mode_after;
    logic [SAMPLE_BITS-1:0] sample_out;

    // Register file written through the plain configuration port.
    ng_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The envelope tracker decides the gain of a sample and the next mode in
    // the same cycle the beat is accepted; the datapath captures its answer.
    ng_env #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TICK_BITS   (TICK_BITS)
    ) u_env (
        .clk          (clk),
        .rst_n        (rst_n),
        .take_audio   (cmd.take_audio),
        .take_command (cmd.take_command),
        .sample_in    (item.sample_in),
        .command_code (item.command_code),
        .cfg          (cfg),
        .mag          (mag),
        .neg          (neg),
        .kind         (kind),
        .num          (num),
        .den          (den),
        .mode_after   (mode_after)
    );

    // The sequencer steps the datapath through multiply, divide, gain and emit.
    ng_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_opcode (item.opcode),
        .item_ready  (item.ready),
        .status      (status),
        .cmd         (cmd)
    );

    ng_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mag           (mag),
        .neg           (neg),
        .kind          (kind),
        .num           (num),
        .den           (den),
        .mode_after    (mode_after),
        .gain          (cfg.output_gain),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .sample_out    (sample_out),
        .gate_mode_out (result.gate_mode_out)
    );

    assign result.sample_out = sample_out;

endmodule

>>> hw/rtl/ng_checker.sv
// Port-level checks of the noise gate over time, bound to the top level.
// Depends on ng_pkg for the mode and opcode codes and on noise_gate_envelope_top.
module ng_checker #(
    parameter int SAMPLE_BITS = ng_pkg::SAMPLE_BITS_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          item_opcode,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [SAMPLE_BITS-1:0]        sample_out,
    input logic [ng_pkg::MODE_BITS-1:0]  gate_mode_out
);
    import ng_pkg::*;

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(sample_out) && $stable(gate_mode_out))
    else $error("stalled result beat changed");

    // An accepted audio sample occupies the sequencer for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_opcode == OPCODE_SAMPLE |=> !item_ready)
    else $error("input accepted again right after an audio sample");

    // A command beat never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item_opcode == OPCODE_COMMAND |=> !$rose(result_valid))
    else $error("result appeared after a command beat");

    // A sample that leaves the gate closed is silent.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && gate_mode_out == MODE_OFF |-> sample_out == '0)
    else $error("closed gate passed a nonzero sample");

endmodule

bind noise_gate_envelope_top ng_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_ng_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .item_opcode   (item.opcode),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .sample_out    (result.sample_out),
    .gate_mode_out (result.gate_mode_out)
);

>>> verif/tb_top.sv
// Self-checking testbench for noise_gate_envelope_top: directed and random beats,
// predicted in-line by a gate envelope model. Depends on ng_pkg, ng_item_if,
// ng_result_if and the noise gate RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ng_pkg::*;

    localparam int SB = SAMPLE_BITS_DEFAULT;
    localparam int TB = TICK_BITS_DEFAULT;
    localparam int unsigned COUNT_MAX = (1 << (TB + 1)) - 1;
    localparam longint unsigned POS_MAX = (64'd1 << (SB - 1)) - 1;
    localparam longint unsigned NEG_MAG = 64'd1 << (SB - 1);
    // Register indexes past the end of the register list; writes must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [SB-1:0] sample;
        ng_mode_t      mode;
    } gated_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    ng_item_if   #(.SAMPLE_BITS(SB)) item_ch ();
    ng_result_if #(.SAMPLE_BITS(SB)) result_ch ();

    noise_gate_envelope_top #(
        .SAMPLE_BITS(SB),
        .TICK_BITS  (TB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    // Shadow copy of the gate registers and envelope state.
    logic [THRESH_BITS-1:0] thr_open;
    logic [THRESH_BITS-1:0] thr_close;
    logic [LENGTH_BITS-1:0] len_attack;
    logic [LENGTH_BITS-1:0] len_hold;
    logic [LENGTH_BITS-1:0] len_release;
    logic [GAIN_BITS-1:0]   gain_q412;
    ng_mode_t               env_mode;
    int unsigned            env_count;

    // Results predicted for accepted audio beats, oldest first.
    gated_beat_t gate_outputs_due[$];

    int send_idle_pct;
    int stall_pct;
    int audio_sent;
    int mismatches;
    int cycles;

    initial begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // The run must end even if the block hangs.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The result side stalls independently on every cycle.
    always @(negedge clk) begin
        result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Every result beat is matched against the oldest prediction.
    always @(posedge clk) begin
        gated_beat_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (gate_outputs_due.size() == 0) begin
                $error("result beat with nothing expected: sample_out %0d gate_mode_out %0d",
                       result_ch.sample_out, result_ch.gate_mode_out);
                mismatches++;
            end else begin
                want = gate_outputs_due.pop_front();
                if (result_ch.sample_out !== want.sample) begin
                    $error("sample_out mismatch: expected %0d, actual %0d",
                           $signed(want.sample), result_ch.sample_out);
                    mismatches++;
                end
                if (result_ch.gate_mode_out !== want.mode) begin
                    $error("gate_mode_out mismatch: expected %0d, actual %0d",
                           want.mode, result_ch.gate_mode_out);
                    mismatches++;
                end
            end
        end
    end

    // Applies a ramp fraction num/den and the Q4.12 output gain to a magnitude,
    // then restores the sign and saturates to the sample width.
    function automatic logic [SB-1:0] amplify(input bit neg, input int unsigned mag,
                                              input longint unsigned num,
                                              input longint unsigned den);
        longint unsigned scaled;
        longint unsigned y;
        if (den == 0) begin
            num = 1;
            den = 1;
        end
        if (num > den) begin
            num = den;
        end
        scaled = (longint'(mag) * num) / den;
        y = (scaled * gain_q412) >> GAIN_FRAC_BITS;
        if (neg) begin
            if (y > NEG_MAG) begin
                y = NEG_MAG;
            end
            return SB'(64'd0 - y);
        end
        if (y > POS_MAX) begin
            y = POS_MAX;
        end
        return SB'(y);
    endfunction

    // Advances the envelope by one beat; returns 1 when the beat yields a result.
    function automatic bit gate_envelope_predict(input logic op,
                                                 input logic signed [SB-1:0] smp,
                                                 input logic [COMMAND_BITS-1:0] code,
                                                 output gated_beat_t outcome);
        int unsigned c;
        int sv;
        bit neg;
        int unsigned mag;
        logic [SB-1:0] y;
        c = env_count;
        outcome.sample = '0;
        outcome.mode = env_mode;
        if (op == OPCODE_COMMAND) begin
            if (code == CMD_BYPASS) begin
                env_mode = MODE_BYPASS;
            end
            return 1'b0;
        end
        sv = smp;
        neg = (sv < 0);
        mag = neg ? -sv : sv;
        case (env_mode)
            MODE_OFF: begin
                y = '0;
                if (mag > thr_open) begin
                    env_mode = MODE_ATTACK;
                    c = 0;
                end
            end
            MODE_ATTACK: begin
                // A zero length is handled inside amplify as full gain.
                y = amplify(neg, mag, c, len_attack);
                if (c >= len_attack) begin
                    env_mode = MODE_ON;
                    c = 0;
                end
            end
            MODE_ON: begin
                y = amplify(neg, mag, 1, 1);
                if (mag < thr_close) begin
                    env_mode = MODE_HOLD;
                    c = 0;
                end
            end
            MODE_HOLD: begin
                y = amplify(neg, mag, 1, 1);
                if (mag > thr_open) begin
                    env_mode = MODE_ON;
                    c = 0;
                end else if (c >= len_hold) begin
                    env_mode = MODE_RELEASE;
                    c = 0;
                end
            end
            MODE_RELEASE: begin
                if (len_release == 0 || c >= len_release) begin
                    y = '0;
                end else begin
                    y = amplify(neg, mag, len_release - c, len_release);
                end
                if (c >= len_release) begin
                    env_mode = MODE_OFF;
                    c = 0;
                end
            end
            default: begin
                env_mode = MODE_BYPASS;
                y = amplify(neg, mag, 1, 1);
            end
        endcase
        if (c < COUNT_MAX) begin
            c++;
        end
        env_count = c;
        outcome.sample = y;
        outcome.mode = env_mode;
        return 1'b1;
    endfunction

    // Presents one beat, starting at a falling edge, and returns at the falling
    // edge after it was taken. The valid line is left high for the next beat.
    task automatic send_item(input logic op, input logic signed [SB-1:0] smp,
                             input logic [COMMAND_BITS-1:0] code);
        gated_beat_t outcome;
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99, 0) < send_idle_pct) begin
                @(negedge clk);
            end
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.sample_in    <= smp;
        item_ch.command_code <= code;
        @(posedge clk);
        while (!item_ch.ready) begin
            @(posedge clk);
        end
        if (gate_envelope_predict(op, smp, code, outcome)) begin
            gate_outputs_due.push_back(outcome);
        end
        if (op == OPCODE_SAMPLE) begin
            audio_sent++;
        end
        @(negedge clk);
    endtask

    task automatic send_audio(input logic signed [SB-1:0] smp);
        send_item(OPCODE_SAMPLE, smp, COMMAND_BITS'($urandom));
    endtask

    // Stops sending and waits until the block has nothing left in flight.
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        while (gate_outputs_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_OPEN_THRESHOLD:  thr_open    = data[THRESH_BITS-1:0];
            REG_CLOSE_THRESHOLD: thr_close   = data[THRESH_BITS-1:0];
            REG_ATTACK_LENGTH:   len_attack  = data;
            REG_HOLD_LENGTH:     len_hold    = data;
            REG_RELEASE_LENGTH:  len_release = data;
            REG_OUTPUT_GAIN:     gain_q412   = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] open_d, input logic [15:0] close_d,
                              input logic [15:0] attack_d, input logic [15:0] hold_d,
                              input logic [15:0] release_d, input logic [15:0] gain_d);
        quiesce();
        write_reg(REG_OPEN_THRESHOLD, open_d);
        write_reg(REG_CLOSE_THRESHOLD, close_d);
        write_reg(REG_ATTACK_LENGTH, attack_d);
        write_reg(REG_HOLD_LENGTH, hold_d);
        write_reg(REG_RELEASE_LENGTH, release_d);
        write_reg(REG_OUTPUT_GAIN, gain_d);
    endtask

    // A sample whose magnitude opens the gate from the current thresholds.
    function automatic logic signed [SB-1:0] loud_sample();
        int m;
        m = $urandom_range(32768, int'(thr_open) + 1);
        if (m == 32768 || $urandom_range(1, 0) == 1) begin
            return SB'(-m);
        end
        return SB'(m);
    endfunction

    // A sample quiet enough to start hold; with a zero close threshold none exists.
    function automatic logic signed [SB-1:0] quiet_sample();
        int m;
        if (thr_close == 0) begin
            return SB'($urandom);
        end
        m = $urandom_range(int'(thr_close) - 1, 0);
        return ($urandom_range(1, 0) == 1) ? SB'(-m) : SB'(m);
    endfunction

    // One open/close cycle: a loud stretch of random length up to four samples
    // past the attack length, then a quiet stretch of up to four samples past
    // hold plus release, with occasional reopening and ignored commands mixed in.
    task automatic envelope_burst();
        int n_loud;
        int n_quiet;
        int k;
        int r;
        n_loud = $urandom_range(int'(len_attack) + 4, 1);
        n_quiet = $urandom_range(int'(len_hold) + int'(len_release) + 4, 1);
        for (k = 0; k < n_loud; k++) begin
            send_audio(loud_sample());
        end
        for (k = 0; k < n_quiet; k++) begin
            r = $urandom_range(99, 0);
            if (r < 5) begin
                send_audio(loud_sample());
            end else if (r < 10) begin
                send_item(OPCODE_COMMAND, SB'($urandom), COMMAND_BITS'($urandom_range(255, 1)));
            end else begin
                send_audio(quiet_sample());
            end
        end
    endtask

    task automatic random_config();
        int open_v;
        int close_v;
        logic [15:0] gain_v;
        logic [15:0] hold_v;
        if ($urandom_range(99, 0) < 15) begin
            open_v = $urandom_range(32767, 0);
            close_v = $urandom_range(32767, 0);
        end else begin
            open_v = $urandom_range(20000, 500);
            close_v = $urandom_range(open_v, 0);
        end
        case ($urandom_range(3, 0))
            0: gain_v = 16'hFFFF;
            1: gain_v = OUTPUT_GAIN_RESET;
            2: gain_v = 16'($urandom);
            default: gain_v = 16'($urandom_range(8192, 1024));
        endcase
        // Now and then a long hold so the counter runs well past eight bits.
        hold_v = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(300, 0))
                                              : 16'($urandom_range(6, 0));
        // Bit 15 of a threshold write must be dropped, so it is set at random.
        set_config({1'($urandom), 15'(open_v)}, {1'($urandom), 15'(close_v)},
                   16'($urandom_range(8, 0)), hold_v, 16'($urandom_range(8, 0)), gain_v);
    endtask

    // Out of reset: thresholds at half scale, zero lengths, unity gain.
    task automatic test_reset_values();
        send_audio(16'sd16384);
        send_audio(-16'sd32768);
        send_audio(16'sd32767);
        send_audio(-16'sd5);
        send_audio(16'sd7);
        send_audio(16'sd3);
    endtask

    // Hysteresis at the exact thresholds, short ramps and a reopen from hold.
    task automatic test_hysteresis();
        int k;
        set_config(16'd1000, 16'd200, 16'd3, 16'd2, 16'd3, 16'd8192);
        write_reg(REG_SPARE_LO, 16'h0000);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        send_audio(16'sd1000);
        send_audio(-16'sd1001);
        send_audio(16'sd3000);
        // Commands other than bypass leave the ramp counter alone.
        send_item(OPCODE_COMMAND, 16'sd0, 8'hA5);
        for (k = 0; k < 3; k++) begin
            send_audio(-16'sd3000);
        end
        send_audio(16'sd500);
        send_audio(-16'sd199);
        send_audio(16'sd1001);
        send_audio(16'sd0);
        send_audio(16'sd50);
        send_audio(-16'sd60);
        for (k = 0; k < 4; k++) begin
            send_audio(16'sd150);
        end
    endtask

    // Ramp and hold lengths lowered below the running counter.
    task automatic test_length_lowered();
        int k;
        set_config(16'd100, 16'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, OUTPUT_GAIN_RESET);
        for (k = 0; k < 3; k++) begin
            send_audio(16'sd32767);
        end
        quiesce();
        write_reg(REG_ATTACK_LENGTH, 16'd1);
        send_audio(-16'sd32767);
        send_audio(16'sd10);
        send_audio(16'sd10);
        quiesce();
        write_reg(REG_HOLD_LENGTH, 16'd1);
        send_audio(16'sd10);
        send_audio(16'sd30000);
        send_audio(-16'sd30000);
        quiesce();
        write_reg(REG_RELEASE_LENGTH, 16'd1);
        send_audio(16'sd30000);
    endtask

    // Threshold and gain extremes: any nonzero sample opens, then saturation.
    task automatic test_extremes();
        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_audio(16'sd0);
        send_audio(16'sd1);
        send_audio(16'sd32767);
        send_audio(-16'sd32768);
        set_config(16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0);
        send_audio(16'sd32767);
        send_audio(16'sd100);
    endtask

    // The bulk of the run: random envelopes under each handshake pressure.
    task automatic test_random_traffic();
        int phase;
        int k;
        int target;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 62; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 62; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            for (k = 0; k < 4; k++) begin
                random_config();
                target = audio_sent + 48;
                while (audio_sent < target) begin
                    if ($urandom_range(99, 0) < 85) begin
                        envelope_burst();
                    end else if ($urandom_range(1, 0) == 1) begin
                        send_audio(SB'($urandom));
                    end else begin
                        send_item(OPCODE_COMMAND, SB'($urandom),
                                  COMMAND_BITS'($urandom_range(255, 1)));
                    end
                end
            end
        end
    endtask

    // Bypass is sticky until reset, so it is the last thing tested.
    task automatic test_bypass();
        int seg;
        int k;
        send_idle_pct = 16;
        stall_pct = 16;
        set_config(16'd2000, 16'd1000, 16'd4, 16'd2, 16'd4, 16'hFFFF);
        send_audio(16'sd100);
        send_item(OPCODE_COMMAND, 16'sd0, 8'hFF);
        send_item(OPCODE_COMMAND, 16'sd0, CMD_BYPASS);
        send_audio(-16'sd32768);
        send_audio(16'sd32767);
        send_audio(16'sd0);
        for (seg = 0; seg < 3; seg++) begin
            quiesce();
            write_reg(REG_OUTPUT_GAIN, 16'($urandom));
            for (k = 0; k < 10; k++) begin
                if ($urandom_range(3, 0) == 0) begin
                    send_item(OPCODE_COMMAND, SB'($urandom), COMMAND_BITS'($urandom));
                end else begin
                    send_audio(SB'($urandom));
                end
            end
        end
    endtask

    initial begin
        // Every input has a known value before the first edge.
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = OPCODE_SAMPLE;
        item_ch.sample_in = '0;
        item_ch.command_code = '0;
        result_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        audio_sent = 0;
        mismatches = 0;
        cycles = 0;

        thr_open = OPEN_THRESHOLD_RESET;
        thr_close = CLOSE_THRESHOLD_RESET;
        len_attack = LENGTH_RESET;
        len_hold = LENGTH_RESET;
        len_release = LENGTH_RESET;
        gain_q412 = OUTPUT_GAIN_RESET;
        env_mode = MODE_OFF;
        env_count = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_hysteresis();
        test_length_lowered();
        test_extremes();
        test_random_traffic();
        test_bypass();

        // Let the last results drain, then watch a while for stray beats.
        item_ch.valid <= 1'b0;
        while (gate_outputs_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
